>>> sv/baseline_tracker_pileup_reject_top_defines.svh
// assertion macros for the baseline tracker
`ifndef BASELINE_TRACKER_PILEUP_REJECT_TOP_DEFINES_SVH
`define BASELINE_TRACKER_PILEUP_REJECT_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define BTPR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BTPR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BTPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/btpr_pkg.sv
// shared types, constants and defaults for the baseline tracker
package btpr_pkg;

  localparam int WINDOW_LEN_DEFAULT  = 16;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam int SAMPLE_IN_W  = 24;
  localparam int DEVIATION_W  = 32;
  localparam int SPREAD_W     = 64;
  localparam int REJECTS_W    = 8;
  localparam int TOTAL_OUT_W  = 28;
  localparam int TALLY_W      = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 64;

  localparam logic [DEVIATION_W-1:0] DEVIATION_RESET = DEVIATION_W'(80);
  localparam logic [SPREAD_W-1:0]    SPREAD_RESET    = SPREAD_W'(6400);
  localparam logic [REJECTS_W-1:0]   REJECTS_RESET   = REJECTS_W'(5);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEVIATION   = 2'd0,
    REG_SPREAD      = 2'd1,
    REG_MAX_REJECTS = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_SPREAD = 2'd1,
    CAUSE_STREAK = 2'd2
  } cause_t;

endpackage

>>> sv/btpr_ram.sv
// generic single write port ram with registered read
module btpr_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/baseline_tracker_pileup_reject_top.sv
// baseline tracker with pileup rejection, top level
//
// Input channel in_valid/in_ready carries one gate sum per transfer (sample).
// Output channel out_valid/out_ready returns one result per input transfer, in
// order: pileup flag, baseline_ready, baseline_total, restart_cause and
// rejected_total, all values after that sample is applied.
// Config channel cfg_valid/cfg_ready (always ready) writes register cfg_index
// with cfg_data: 0 deviation limit, 1 spread limit, 2 max consecutive rejects.
// A result passes the input register and the provisional result register before
// the output register. Throughput is one sample per cycle while out_ready holds
// no result back; the window state update, including the N*sum_sq - sum^2 spread
// test of the previous sample, is combinational around one sum x sum multiplier.
// The window is a ram holding each sample and its square; no clearing pass is
// needed since an entry is only read once the window has been filled.
// Reset (rst, synchronous) empties the window, clears all counts and loads the
// default limits. While a result waits on out_ready the whole pipeline holds and
// in_ready drops once the input register is occupied.
module baseline_tracker_pileup_reject_top #(
  parameter int WINDOW_LEN  = btpr_pkg::WINDOW_LEN_DEFAULT,
  parameter int SAMPLE_BITS = btpr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [btpr_pkg::SAMPLE_IN_W-1:0]    sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                pileup,
  output logic                                baseline_ready,
  output logic [btpr_pkg::TOTAL_OUT_W-1:0]    baseline_total,
  output logic [1:0]                          restart_cause,
  output logic [btpr_pkg::TALLY_W-1:0]        rejected_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [btpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  `include "baseline_tracker_pileup_reject_top_defines.svh"

  localparam int N        = WINDOW_LEN;
  localparam int S        = SAMPLE_BITS;
  localparam int SLOT_W   = (N > 1) ? $clog2(N) : 1;
  localparam int FILL_W   = $clog2(N + 1);
  localparam int TOT_W    = S + $clog2(N);
  localparam int SQ_W     = 2 * S + $clog2(N);
  localparam int NSQ_W    = SQ_W + $clog2(N);
  localparam int TSQ_W    = 2 * TOT_W;
  localparam int CMP_BASE = (NSQ_W > TSQ_W) ? NSQ_W : TSQ_W;
  localparam int CMP_W    = ((CMP_BASE > btpr_pkg::SPREAD_W) ? CMP_BASE : btpr_pkg::SPREAD_W) + 1;
  localparam int DCMP_W   = (TOT_W > btpr_pkg::DEVIATION_W) ? TOT_W : btpr_pkg::DEVIATION_W;
  localparam int RAM_W    = 3 * S;
  localparam int WIDE_IN  = 32;
  localparam int STREAK_W = 8;

  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(N - 1);
  localparam logic [SLOT_W-1:0] SLOT_AFTER_FIRST = SLOT_W'(1 % N);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(N);
  localparam logic              ONE_FILLS  = (N == 1);

  // configuration
  logic [btpr_pkg::DEVIATION_W-1:0] dev_limit;
  logic [btpr_pkg::SPREAD_W-1:0]    spread_limit;
  logic [btpr_pkg::REJECTS_W-1:0]   max_rejects;

  // window state
  logic [FILL_W-1:0]            fill, fill_next;
  logic [SLOT_W-1:0]            slot, slot_next;
  logic [TOT_W-1:0]             total, total_next;
  logic [SQ_W-1:0]              sq, sq_next;
  logic [STREAK_W-1:0]          streak, streak_next;
  logic [btpr_pkg::TALLY_W-1:0] tally, tally_next;

  // input register
  logic         r0_valid;
  logic [S-1:0] r0_x;
  logic [2*S-1:0] r0_xsq;

  // provisional result register
  logic                         r1_valid;
  logic                         r1_pileup;
  logic                         r1_ready;
  logic [TOT_W-1:0]             r1_total;
  logic                         r1_streak_restart;
  logic                         r1_check;
  logic [btpr_pkg::TALLY_W-1:0] r1_tally;

  // window ram and forwarding
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic              fwd_hit;
  logic [RAM_W-1:0]  fwd_data;
  logic [RAM_W-1:0]  old_entry;
  logic [S-1:0]      old_x;
  logic [2*S-1:0]    old_sq;

  logic [WIDE_IN-1:0] sample_wide;
  logic [S-1:0]       in_x;

  logic move;
  logic do_update;

  // spread test on committed state
  logic [NSQ_W-1:0] nsq;
  logic [TSQ_W-1:0] total_sq;
  logic             spread_over;
  logic             restart_now;

  // update on committed state
  logic                         full;
  logic [TOT_W-1:0]             scaled;
  logic [TOT_W-1:0]             dev;
  logic                         a_pile;
  logic [FILL_W-1:0]            a_fill;
  logic [SLOT_W-1:0]            a_slot;
  logic [TOT_W-1:0]             a_total;
  logic [SQ_W-1:0]              a_sq;
  logic [STREAK_W-1:0]          a_streak;
  logic [btpr_pkg::TALLY_W-1:0] a_tally;
  logic                         a_streak_restart;

  // selected update
  logic                         u_pile;
  logic                         u_store;
  logic [SLOT_W-1:0]            u_wslot;
  logic [FILL_W-1:0]            u_fill;
  logic [SLOT_W-1:0]            u_slot;
  logic [TOT_W-1:0]             u_total;
  logic [SQ_W-1:0]              u_sq;
  logic [STREAK_W-1:0]          u_streak;
  logic [btpr_pkg::TALLY_W-1:0] u_tally;
  logic                         u_streak_restart;
  logic                         u_check;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_limit    <= btpr_pkg::DEVIATION_RESET;
      spread_limit <= btpr_pkg::SPREAD_RESET;
      max_rejects  <= btpr_pkg::REJECTS_RESET;
    end else if (cfg_valid) begin
      case (btpr_pkg::reg_index_t'(cfg_index))
        btpr_pkg::REG_DEVIATION: begin
          dev_limit <= cfg_data[btpr_pkg::DEVIATION_W-1:0];
        end
        btpr_pkg::REG_SPREAD: begin
          spread_limit <= cfg_data[btpr_pkg::SPREAD_W-1:0];
        end
        btpr_pkg::REG_MAX_REJECTS: begin
          max_rejects <= cfg_data[btpr_pkg::REJECTS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign move      = !out_valid || out_ready;
  assign in_ready  = move || !r0_valid;
  assign do_update = move && r0_valid;

  assign sample_wide = WIDE_IN'(sample);
  assign in_x        = sample_wide[S-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (in_ready) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r0_x   <= in_x;
      r0_xsq <= (2*S)'(in_x) * (2*S)'(in_x);
    end
  end

  assign old_entry = fwd_hit ? fwd_data : ram_rdata;
  assign old_x     = old_entry[S-1:0];
  assign old_sq    = old_entry[RAM_W-1:S];

  // spread of the last stored sample, tested on the committed window state
  assign nsq         = NSQ_W'(sq) * NSQ_W'(N);
  assign total_sq    = TSQ_W'(total) * TSQ_W'(total);
  assign spread_over = CMP_W'(nsq) > (CMP_W'(total_sq) + CMP_W'(spread_limit));
  assign restart_now = r1_valid && r1_check && spread_over;

  // normal path on the committed window
  always_comb begin
    full             = (fill == FILL_FULL);
    scaled           = TOT_W'(r0_x) * TOT_W'(N);
    dev              = (scaled >= total) ? (scaled - total) : (total - scaled);
    a_pile           = full && (DCMP_W'(dev) > DCMP_W'(dev_limit));
    a_fill           = fill;
    a_slot           = slot;
    a_total          = total;
    a_sq             = sq;
    a_streak         = streak;
    a_tally          = tally;
    a_streak_restart = 1'b0;
    if (a_pile) begin
      a_tally  = (tally == '1) ? tally : tally + 1'b1;
      a_streak = (streak == '1) ? streak : streak + 1'b1;
    end else begin
      a_streak = '0;
      if (full) begin
        a_total = total - TOT_W'(old_x) + TOT_W'(r0_x);
        a_sq    = sq - SQ_W'(old_sq) + SQ_W'(r0_xsq);
      end else begin
        a_total = total + TOT_W'(r0_x);
        a_sq    = sq + SQ_W'(r0_xsq);
        a_fill  = fill + 1'b1;
      end
      a_slot = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    end
    if (a_streak > max_rejects) begin
      a_streak_restart = 1'b1;
      a_fill           = '0;
      a_slot           = '0;
      a_total          = '0;
      a_sq             = '0;
      a_streak         = '0;
      a_tally          = '0;
    end
  end

  // after a spread restart the sample lands in an empty window
  always_comb begin
    if (restart_now) begin
      u_pile           = 1'b0;
      u_store          = 1'b1;
      u_wslot          = '0;
      u_fill           = FILL_W'(1);
      u_slot           = SLOT_AFTER_FIRST;
      u_total          = TOT_W'(r0_x);
      u_sq             = SQ_W'(r0_xsq);
      u_streak         = '0;
      u_tally          = '0;
      u_streak_restart = 1'b0;
      u_check          = ONE_FILLS;
    end else begin
      u_pile           = a_pile;
      u_store          = !a_pile;
      u_wslot          = slot;
      u_fill           = a_fill;
      u_slot           = a_slot;
      u_total          = a_total;
      u_sq             = a_sq;
      u_streak         = a_streak;
      u_tally          = a_tally;
      u_streak_restart = a_streak_restart;
      u_check          = !a_pile && (a_fill == FILL_FULL);
    end
  end

  always_comb begin
    fill_next   = fill;
    slot_next   = slot;
    total_next  = total;
    sq_next     = sq;
    streak_next = streak;
    tally_next  = tally;
    if (do_update) begin
      fill_next   = u_fill;
      slot_next   = u_slot;
      total_next  = u_total;
      sq_next     = u_sq;
      streak_next = u_streak;
      tally_next  = u_tally;
    end else if (move && restart_now) begin
      fill_next   = '0;
      slot_next   = '0;
      total_next  = '0;
      sq_next     = '0;
      streak_next = '0;
      tally_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      slot   <= '0;
      total  <= '0;
      sq     <= '0;
      streak <= '0;
      tally  <= '0;
    end else begin
      fill   <= fill_next;
      slot   <= slot_next;
      total  <= total_next;
      sq     <= sq_next;
      streak <= streak_next;
      tally  <= tally_next;
    end
  end

  assign ram_we    = do_update && u_store;
  assign ram_waddr = u_wslot;
  assign ram_wdata = {r0_xsq, r0_x};

  btpr_ram #(
    .WIDTH     (RAM_W),
    .DEPTH     (N),
    .ADDR_BITS (SLOT_W)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_next),
    .rdata (ram_rdata)
  );

  // write and read of the same slot in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (ram_waddr == slot_next);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= ram_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (move) begin
      r1_valid <= do_update;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      r1_pileup         <= u_pile;
      r1_ready          <= (u_fill == FILL_FULL);
      r1_total          <= u_total;
      r1_streak_restart <= u_streak_restart;
      r1_check          <= u_check;
      r1_tally          <= u_tally;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && r1_valid) begin
      pileup <= r1_pileup;
      if (restart_now) begin
        baseline_ready <= 1'b0;
        baseline_total <= '0;
        restart_cause  <= btpr_pkg::CAUSE_SPREAD;
        rejected_total <= '0;
      end else begin
        baseline_ready <= r1_ready;
        baseline_total <= btpr_pkg::TOTAL_OUT_W'(r1_total);
        restart_cause  <= r1_streak_restart ? btpr_pkg::CAUSE_STREAK : btpr_pkg::CAUSE_NONE;
        rejected_total <= r1_tally;
      end
    end
  end

  `BTPR_ASSERT_ALWAYS(a_fill_bound, fill <= FILL_FULL, "fill level beyond window length")
  `BTPR_ASSERT_IMPLIES(a_streak_full, streak != '0, fill == FILL_FULL,
                       "reject streak with a window that is not full")
  `BTPR_ASSERT_IMPLIES(a_check_full, r1_valid && r1_check, fill == FILL_FULL,
                       "spread test pending on a window that is not full")
  `BTPR_ASSERT_IMPLIES(a_spread_result, out_valid && restart_cause == btpr_pkg::CAUSE_SPREAD,
                       !pileup && !baseline_ready && baseline_total == '0 && rejected_total == '0,
                       "spread restart result not cleared")
  `BTPR_ASSERT_NEXT(a_restart_clears, move && restart_now, fill <= FILL_W'(1),
                    "window not emptied after spread restart")

endmodule
